// ===== hdl/pcx_rle_pkg.sv =====
// Shared types and constants for the bilevel PCX run-length decoder.
package pcx_rle_pkg;

   localparam int CODE_W      = 8;   // one compressed byte
   localparam int COUNT_W     = 6;   // repeat count of a run header
   localparam int CFG_W       = 13;  // image size registers
   localparam int POS_W       = 12;  // row and column fields of a result
   localparam int VCNT_W      = 4;   // valid pixel count of a result
   localparam int GROUP_PIX   = 8;   // pixels carried by one byte
   localparam int CSR_IDX_W   = 1;
   localparam int RSP_DATA_W  = 40;  // result fields padded to whole bytes

   localparam logic [1:0] RUN_TAG = 2'b11;  // top two bits of a run header

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   // One queued piece of work: a data byte and how many groups it makes
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [CODE_W-1:0]  code;
   } run_word_type;

   // Handshake between the queue and the group engine
   typedef struct packed {
      logic         valid;
      run_word_type word;
   } queue_head_type;

endpackage

// ===== hdl/pcx_rle_front.sv =====
// Front end: parses run headers and literals and queues data bytes with their counts.
module pcx_rle_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [pcx_rle_pkg::CODE_W-1:0] req_tdata,
   input  logic                         push_full,
   output logic                         push_valid,
   output pcx_rle_pkg::run_word_type    push_word
);
   import pcx_rle_pkg::*;

   logic               run_pending_ff, run_pending_in;
   logic [COUNT_W-1:0] run_length_ff, run_length_in;
   logic               accept;
   logic               is_header;

   assign req_tready = ~push_full;
   assign accept     = req_tvalid & ~push_full;
   assign is_header  = (req_tdata[CODE_W-1 -: 2] == RUN_TAG);

   // Classify the byte: run data, run header or literal
   always_comb begin
      run_pending_in  = run_pending_ff;
      run_length_in   = run_length_ff;
      push_valid      = 1'b0;
      push_word.code  = req_tdata;
      push_word.count = COUNT_W'(1);
      if (run_pending_ff) begin
         push_word.count = run_length_ff;
         // a zero-length run swallows its data byte
         push_valid      = accept & (run_length_ff != '0);
         if (accept) begin
            run_pending_in = 1'b0;
            run_length_in  = '0;
         end
      end else if (is_header) begin
         if (accept) begin
            run_pending_in = 1'b1;
            run_length_in  = req_tdata[COUNT_W-1:0];
         end
      end else begin
         push_valid = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_pending_ff <= 1'b0;
         run_length_ff  <= '0;
      end else begin
         run_pending_ff <= run_pending_in;
         run_length_ff  <= run_length_in;
      end
   end

endmodule

// ===== hdl/pcx_rle_fifo.sv =====
// Two-entry queue between the byte parser and the group engine.
module pcx_rle_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push_valid,
   input  pcx_rle_pkg::run_word_type      push_word,
   output logic                           push_full,
   output pcx_rle_pkg::queue_head_type    head,
   input  logic                           pop
);
   import pcx_rle_pkg::*;

   run_word_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         do_push, do_pop;

   assign push_full  = (fill_ff == 2'd2);
   assign do_push    = push_valid & ~push_full;
   assign do_pop     = pop & (fill_ff != 2'd0);
   assign head.valid = (fill_ff != 2'd0);
   assign head.word  = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push & ~do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop & ~do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== hdl/pcx_rle_back.sv =====
// Back end: expands queued bytes into pixel groups, tracks position and clipping.
module pcx_rle_back #(
   parameter int DIM_W = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              recalc,
   input  logic [DIM_W-1:0]                  dim_w,
   input  logic [DIM_W-1:0]                  dim_h,
   input  pcx_rle_pkg::queue_head_type       head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pcx_rle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser
);
   import pcx_rle_pkg::*;

   localparam int RW = 2 * DIM_W;  // remaining pixel count
   localparam int MW = DIM_W + 3;  // room for eight row widths

   typedef enum logic [1:0] {
      ST_PROD,  // multiply rows left by width
      ST_REM,   // subtract the column offset
      ST_RUN    // expand bytes into groups
   } state_type;

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic               fin_ff, fin_in;
   logic [COUNT_W-1:0] grp_ff, grp_in;
   logic [RW-1:0]      prod_ff, prod_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  bits_ff, bits_in;
   logic [VCNT_W-1:0]  vcnt_ff, vcnt_in;
   logic [POS_W-1:0]   prow_ff, prow_in;
   logic [POS_W-1:0]   pcol_ff, pcol_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;

   logic               wrap;
   logic [DIM_W-1:0]   erow, ecol, diff;
   logic               out_free, emit, end_img, last_grp;
   logic [DIM_W:0]     adv_col;
   logic [DIM_W-1:0]   adv_row;
   logic [MW-1:0]      span, span_wr;
   logic [VCNT_W-1:0]  wraps;

   // Position after the lazy wrap that a narrowed width may call for
   assign wrap = (col_ff >= dim_w);
   assign erow = row_ff + DIM_W'(wrap);
   assign ecol = wrap ? '0 : col_ff;
   assign diff = (erow < dim_h) ? (dim_h - erow) : '0;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign end_img  = (rem_ff <= RW'(GROUP_PIX));
   assign last_grp = (grp_ff + COUNT_W'(1) == head.word.count) | end_img;

   // Step the position across eight pixels; row ends crossed are found in parallel
   always_comb begin
      span    = MW'(ecol) + MW'(GROUP_PIX);
      span_wr = '0;
      wraps   = '0;
      for (int k = 1; k <= GROUP_PIX; k++) begin
         if (span >= MW'(dim_w) * MW'(k)) begin
            wraps   = VCNT_W'(k);
            span_wr = MW'(dim_w) * MW'(k);
         end
      end
      adv_col = (DIM_W + 1)'(span - span_wr);
      adv_row = erow + DIM_W'(wraps);
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fin_in       = fin_ff;
      grp_in       = grp_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      bits_in      = bits_ff;
      vcnt_in      = vcnt_ff;
      prow_in      = prow_ff;
      pcol_in      = pcol_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      pop          = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         ST_PROD: begin
            prod_in  = RW'(diff) * RW'(dim_w);
            state_in = ST_REM;
         end
         ST_REM: begin
            rem_in   = prod_ff - RW'(ecol);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (head.valid) begin
               if (fin_ff || (erow >= dim_h)) begin
                  // image complete: byte is consumed without output
                  pop    = 1'b1;
                  fin_in = 1'b1;
                  grp_in = '0;
               end else if (out_free) begin
                  emit         = 1'b1;
                  pop          = last_grp;
                  grp_in       = last_grp ? '0 : grp_ff + COUNT_W'(1);
                  fin_in       = end_img;
                  rem_in       = rem_ff - RW'(GROUP_PIX);
                  row_in       = adv_row;
                  col_in       = adv_col[DIM_W-1:0];
                  rsp_valid_in = 1'b1;
                  bits_in      = head.word.code;
                  vcnt_in      = (rem_ff < RW'(GROUP_PIX)) ? rem_ff[VCNT_W-1:0]
                                                           : VCNT_W'(GROUP_PIX);
                  prow_in      = POS_W'(erow);
                  pcol_in      = POS_W'(ecol);
                  last_in      = last_grp;
                  done_in      = end_img;
               end
            end
         end
         default: begin
            state_in = ST_PROD;
         end
      endcase
      // size change: recompute the remaining count
      if (recalc) begin
         state_in = ST_PROD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PROD;
         row_ff       <= '0;
         col_ff       <= '0;
         fin_ff       <= 1'b0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         fin_ff       <= fin_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      if (emit) begin
         bits_ff <= bits_in;
         vcnt_ff <= vcnt_in;
         prow_ff <= prow_in;
         pcol_ff <= pcol_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({pcol_ff, prow_ff, vcnt_ff, bits_ff});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

// ===== hdl/pcx_rle_bilevel_decoder_top.sv =====
// Top level of the bilevel PCX run-length decoder: size registers and block wiring.
//
//   channel  direction  payload
//   req_     in         tdata[7:0] code_byte
//   rsp_     out        tdata pixel_bits, valid_count, pixel_row, pixel_col;
//                       tlast run_last; tuser image_done
//   csr_     in         index (0 image_width, 1 image_height), wdata 13 bits
//
// A literal byte makes one group; a run data byte makes one group per repeat
// (up to 63), emitted by the group engine at one group a cycle while the output
// is not stalled. Headers and zero-length runs are absorbed by the parser.
// Reset is synchronous; after reset and after each register write the engine
// recomputes the remaining pixel count (one multiply, then one subtraction).
// The two-entry queue lets the parser keep taking bytes while the output stalls.
module pcx_rle_bilevel_decoder_top #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [pcx_rle_pkg::CODE_W-1:0]        req_tdata,   // [7:0] code_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] pixel_bits, [11:8] valid_count, [23:12] pixel_row, [35:24] pixel_col
   output logic [pcx_rle_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tlast,   // run_last
   output logic                                  rsp_tuser,   // [0] image_done
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcx_rle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcx_rle_pkg::CFG_W-1:0]         csr_wdata
);
   import pcx_rle_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             csr_write;
   logic [DIM_W-1:0] dim_w, dim_h;
   logic             push_full, push_valid, pop;
   run_word_type     push_word;
   queue_head_type   head;

   // Zero acts as one, anything above the limit acts as the limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      if (ext == '0) begin
         return DIM_W'(1);
      end else if (ext > CW'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(ext);
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Size register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign dim_w = clamp_dim(width_ff);
   assign dim_h = clamp_dim(height_ff);

   pcx_rle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_full  (push_full),
      .push_valid (push_valid),
      .push_word  (push_word)
   );

   pcx_rle_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_full  (push_full),
      .head       (head),
      .pop        (pop)
   );

   pcx_rle_back #(
      .DIM_W (DIM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .recalc     (csr_write),
      .dim_w      (dim_w),
      .dim_h      (dim_h),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/tb_pcx_rle_bilevel_decoder_top.sv =====
// Self-checking testbench for the bilevel PCX run-length decoder top level.
`timescale 1ns / 1ps

module tb_pcx_rle_bilevel_decoder_top;
   import pcx_rle_pkg::*;

   localparam int MAX_DIM       = 4096;
   localparam int HALF_PERIOD   = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int REPORT_LIMIT  = 10;
   localparam int STALL_CYCLES  = 300;
   localparam int IDLE_PERCENT  = 9;

   // One decoded group of eight pixels as it leaves the block
   typedef struct {
      logic [CODE_W-1:0] pix;
      logic [VCNT_W-1:0] vcount;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic              last;
      logic              done;
   } pixel_group_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [CODE_W-1:0]          req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_W-1:0]      rsp_tdata;
   logic                       rsp_tlast;
   logic                       rsp_tuser;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CFG_W-1:0]           csr_wdata;

   // Predictor state: size registers and decoder position
   logic [CFG_W-1:0]   width_reg;
   logic [CFG_W-1:0]   height_reg;
   logic               run_armed;
   logic [COUNT_W-1:0] run_count;
   int unsigned        row_pos;
   int unsigned        col_pos;
   logic               image_complete;

   pixel_group_type pending_groups[$];

   int failures;
   int words_sent;
   int groups_checked;
   int reg_writes;
   int cycle_count;
   int stall_request;
   int hold_left;
   logic steady;

   pcx_rle_bilevel_decoder_top #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d groups outstanding", cycle_count,
                  pending_groups.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Out of range sizes act as the nearest legal value
   function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // Expand one accepted code word into the pixel groups it should produce
   task automatic decode_code(input logic [CODE_W-1:0] b);
      int unsigned reps;
      int unsigned w;
      int unsigned h;
      int unsigned remaining;
      int unsigned left;
      int unsigned room;
      int unsigned adv;
      pixel_group_type g;
      pixel_group_type made[$];
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      if (run_armed) begin
         reps = run_count;
         run_armed = 1'b0;
         run_count = '0;
      end else if (b[7:6] == RUN_TAG) begin
         run_armed = 1'b1;
         run_count = b[COUNT_W-1:0];
         return;
      end else begin
         reps = 1;
      end
      while (reps > 0 && !image_complete) begin
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) begin
            image_complete = 1'b1;
            break;
         end
         remaining = (h - row_pos) * w - col_pos;
         g.pix    = b;
         g.vcount = (remaining < GROUP_PIX) ? remaining[VCNT_W-1:0] : VCNT_W'(GROUP_PIX);
         g.row    = row_pos[POS_W-1:0];
         g.col    = col_pos[POS_W-1:0];
         g.last   = 1'b0;
         g.done   = (remaining <= GROUP_PIX);
         made.push_back(g);
         // advance eight pixels, flowing across row ends
         left = GROUP_PIX;
         while (left > 0 && row_pos < h) begin
            room = w - col_pos;
            adv = (left < room) ? left : room;
            col_pos += adv;
            left -= adv;
            if (col_pos >= w) begin
               col_pos = 0;
               row_pos++;
            end
         end
         if (remaining <= GROUP_PIX || row_pos >= h) begin
            image_complete = 1'b1;
            row_pos = h;
            col_pos = 0;
         end
         reps--;
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) pending_groups.push_back(made[i]);
   endtask

   // Offer one code word, with random gaps, until accepted
   task automatic send_code(input logic [CODE_W-1:0] b);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      decode_code(b);
      words_sent++;
   endtask

   // Drop the input and wait until every expected group has come out
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_groups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, a long hold on request, steady stretch
   always @(negedge clock) begin
      if (stall_request != 0) begin
         hold_left = stall_request;
         stall_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Result checker: sample at the edge, compare once the predictor has run
   always @(posedge clock) begin : group_check
      logic fire;
      pixel_group_type got;
      pixel_group_type want;
      fire = !reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1;
      got.pix    = rsp_tdata[7:0];
      got.vcount = rsp_tdata[11:8];
      got.row    = rsp_tdata[23:12];
      got.col    = rsp_tdata[35:24];
      got.last   = rsp_tlast;
      got.done   = rsp_tuser;
      #1;
      if (fire) begin
         groups_checked++;
         if (pending_groups.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("Unexpected group: pix %h cnt %0d row %0d col %0d last %b done %b",
                        got.pix, got.vcount, got.row, got.col, got.last, got.done);
         end else begin
            want = pending_groups.pop_front();
            if (got.pix !== want.pix || got.vcount !== want.vcount || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last || got.done !== want.done) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("Group mismatch at cycle %0d", cycle_count);
                  $display("  exp pix %h cnt %0d row %0d col %0d last %b done %b",
                           want.pix, want.vcount, want.row, want.col, want.last, want.done);
                  $display("  got pix %h cnt %0d row %0d col %0d last %b done %b",
                           got.pix, got.vcount, got.row, got.col, got.last, got.done);
               end
            end
         end
      end
   end

   // Literal bytes: edge patterns whose top two bits are not both set
   task automatic test_literals();
      send_code(8'h00);
      send_code(8'hBF);
      send_code(8'h7F);
      send_code(8'h80);
      send_code(8'h01);
   endtask

   // Runs: zero length, longest, header-shaped data bytes
   task automatic test_runs();
      send_code({RUN_TAG, 6'd0});
      send_code(8'hC7);
      send_code({RUN_TAG, 6'd63});
      send_code(8'h55);
      send_code({RUN_TAG, 6'd1});
      send_code(8'hC3);
      send_code({RUN_TAG, 6'd2});
      send_code(8'hFF);
   endtask

   // Narrowing the width mid-image pushes the position to the next row
   task automatic test_width_wrap();
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd5);
      send_code(8'h5A);
      send_code(8'hA5);
      send_code({RUN_TAG, 6'd3});
      send_code(8'h0F);
   endtask

   // Random words at one width: mostly runs and literals, some stray bytes
   task automatic test_random_phase(input logic [CFG_W-1:0] width_value, input int n_words,
                                    input int max_run);
      int sent;
      int pick;
      logic [CODE_W-1:0] b;
      settle();
      write_reg(CSR_IMAGE_WIDTH, width_value);
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_code({RUN_TAG, COUNT_W'($urandom_range(0, max_run))});
            send_code(CODE_W'($urandom_range(0, 255)));
            sent += 2;
         end else if (pick < 90) begin
            send_code(CODE_W'($urandom_range(0, 191)));
            sent++;
         end else begin
            // stray byte: may break a run apart
            b = CODE_W'($urandom_range(0, 255));
            if (b[7:6] == RUN_TAG) b[5:0] = COUNT_W'(b[5:0] % (max_run + 1));
            send_code(b);
            sent++;
         end
      end
   endtask

   // Size register sweep, with the output held off once and a steady stretch
   task automatic test_random();
      settle();
      write_reg(CSR_IMAGE_HEIGHT, CFG_W'($urandom_range(MAX_DIM + 1, 8191)));
      test_random_phase(13'd0, 15, 3);
      test_random_phase(13'd1, 15, 3);
      test_random_phase(13'd7, 25, 8);
      settle();
      write_reg(CSR_IMAGE_HEIGHT, 13'(MAX_DIM));
      test_random_phase(CFG_W'($urandom_range(9, 64)), 40, 20);
      steady = 1'b1;
      test_random_phase(CFG_W'($urandom_range(65, 700)), 50, 63);
      steady = 1'b0;
      settle();
      stall_request = STALL_CYCLES;
      test_random_phase(13'(MAX_DIM), 50, 63);
      settle();
      write_reg(CSR_IMAGE_HEIGHT, 13'd8191);
      test_random_phase(13'd8191, 40, 63);
      test_random_phase(CFG_W'($urandom_range(1000, MAX_DIM)), 40, 63);
   endtask

   // Image end: clipped final group cut from a run, then bytes that give nothing
   task automatic test_image_end();
      int unsigned start_row;
      int unsigned start_col;
      int unsigned rows;
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd13);
      start_row = (col_pos >= 13) ? row_pos + 1 : row_pos;
      start_col = (col_pos >= 13) ? 0 : col_pos;
      // pick a height that leaves a partial last group
      rows = ((26 - start_col) % GROUP_PIX != 0) ? 2 : 3;
      write_reg(CSR_IMAGE_HEIGHT, CFG_W'(start_row + rows));
      send_code({RUN_TAG, 6'd63});
      send_code(8'hA5);
      while (!image_complete) send_code(CODE_W'($urandom_range(0, 191)));
      send_code({RUN_TAG, 6'd4});
      send_code(8'h81);
      send_code(8'h3C);
      send_code(8'h00);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      run_armed = 1'b0;
      run_count = '0;
      row_pos = 0;
      col_pos = 0;
      image_complete = 1'b0;
      failures = 0;
      words_sent = 0;
      groups_checked = 0;
      reg_writes = 0;
      cycle_count = 0;
      stall_request = 0;
      hold_left = 0;
      steady = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_literals();
      test_runs();
      test_width_wrap();
      test_random();
      test_image_end();
      settle();

      if (pending_groups.size() != 0) begin
         $display("%0d expected groups never arrived", pending_groups.size());
         failures += pending_groups.size();
      end
      $display("Decoded %0d code words into %0d pixel groups across %0d size writes,",
               words_sent, groups_checked, reg_writes);
      $display("including widths 0..8191, a long output hold and a clipped image end.");
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures", failures);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
